// File: design/assert_macros.svh
// Assertion helpers used by the checker file.
// Each macro takes a label, an antecedent and a consequent, sampled on clk,
// and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define CHK_IMP(lbl, ant, con) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (con)) \
    else $error("assertion failed");

// Next-cycle implication
`define CHK_NXT(lbl, ant, con) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (con)) \
    else $error("assertion failed");

`endif

// File: design/fbf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbf_pkg
// Types, codes and helpers for the facet basis function evaluator.
// ----------------------------------------------------------------------------
package fbf_pkg;

  typedef enum logic [2:0] {
    EL_LINE    = 3'd0,
    EL_TRI     = 3'd1,
    EL_QUAD    = 3'd2,
    EL_TET     = 3'd3,
    EL_HEX     = 3'd4,
    EL_PRISM   = 3'd5,
    EL_PYRAMID = 3'd6,
    EL_UNKNOWN = 3'd7
  } elem_e;

  typedef enum logic [1:0] {
    ERR_OK    = 2'd0,
    ERR_FACET = 2'd1,
    ERR_ELEM  = 2'd2,
    ERR_SAT   = 2'd3
  } err_e;

  typedef struct packed {
    logic [2:0]        element_type;
    logic [2:0]        facet_number;
    logic signed [15:0] coord_u;
    logic signed [15:0] coord_v;
    logic signed [15:0] coord_w;
    logic              facet_reversed;
  } in_word_t;

  typedef struct packed {
    logic signed [23:0] vec_x;
    logic signed [23:0] vec_y;
    logic signed [23:0] vec_z;
    logic signed [23:0] divergence;
    logic [1:0]         error_code;
  } out_word_t;

  // one saturated output value
  typedef struct packed {
    logic               sat;
    logic signed [23:0] val;
  } res_t;

  // per-item data that rides alongside the divider
  typedef struct packed {
    err_e              err;
    logic              div_sel;
    logic [3:0]        sat;
    logic [3:0][23:0]  val;
  } side_t;

  localparam logic signed [23:0] OUT_MAX = 24'sh7FFFFF;
  localparam logic signed [23:0] OUT_MIN = 24'sh800000;

  // quotient bits kept by the divider (one beyond the rounding bit of 24 bits)
  localparam int QUOT_BITS  = 25;
  localparam int DIV_STEPS  = 5;
  localparam int DIV_STAGES = (QUOT_BITS + DIV_STEPS - 1) / DIV_STEPS;

  // width helpers, all constant functions of the fraction widths
  function automatic int mx_of(int inf);
    return (inf > 15) ? inf : 15;
  endfunction

  function automatic int dw_of(int inf);
    return mx_of(inf) + 3;
  endfunction

  function automatic int pw_of(int inf);
    return dw_of(inf) + mx_of(inf) + 4;
  endfunction

  function automatic int nw_of(int inf, int outf);
    int e;
    e = outf - inf - 1;
    return pw_of(inf) + ((e > 0) ? e : 0);
  endfunction

  // sign, clamp and flag one magnitude
  function automatic res_t sat24(logic neg, logic [24:0] mag, logic big);
    res_t res;
    res.sat = big | (neg ? (mag > 25'd8388608) : (mag > 25'd8388607));
    if (res.sat) begin
      res.val = neg ? OUT_MIN : OUT_MAX;
    end else begin
      res.val = neg ? 24'(-mag) : 24'(mag);
    end
    return res;
  endfunction

endpackage

// File: design/fbf_numer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbf_numer
// Two pipeline stages: decode and products, then numerators, rounding of the
// linear results and divider operands for the pyramid x/y components.
// ----------------------------------------------------------------------------
module fbf_numer #(
  parameter int IN_FRAC_BITS  = 14,
  parameter int OUT_FRAC_BITS = 16
) (
  input  logic                                          clk,
  input  logic                                          en,
  input  fbf_pkg::in_word_t                             in_data,
  output fbf_pkg::side_t                                side_o,
  output logic [fbf_pkg::nw_of(IN_FRAC_BITS, OUT_FRAC_BITS)-1:0] pnum_o,
  output logic [fbf_pkg::nw_of(IN_FRAC_BITS, OUT_FRAC_BITS)-1:0] qnum_o,
  output logic [fbf_pkg::dw_of(IN_FRAC_BITS)-1:0]       den_o,
  output logic                                          pneg_o,
  output logic                                          qneg_o
);
  import fbf_pkg::*;

  localparam int MX  = mx_of(IN_FRAC_BITS);
  localparam int WL  = MX + 9;
  localparam int DW  = dw_of(IN_FRAC_BITS);
  localparam int PW  = pw_of(IN_FRAC_BITS);
  localparam int NW  = nw_of(IN_FRAC_BITS, OUT_FRAC_BITS);
  localparam int ADW = DW + 16;
  // linear results are n / 2^(IN+2); scale by 2^OUT
  localparam int K   = OUT_FRAC_BITS - IN_FRAC_BITS - 2;
  localparam int KL  = (K > 0) ? K : 0;
  localparam int KR  = (K < 0) ? -K : 0;
  localparam int QWL = WL + KL + 2;
  localparam logic [QWL-1:0] HALF = (QWL'(1) << KR) >> 1;
  // divider numerator keeps one extra bit for the final rounding
  localparam int E   = OUT_FRAC_BITS - IN_FRAC_BITS - 1;
  localparam int EL  = (E > 0) ? E : 0;
  localparam int ER  = (E < 0) ? -E : 0;
  localparam logic signed [WL-1:0] S_L = WL'(1) <<< IN_FRAC_BITS;

  function automatic res_t lin_round(logic signed [WL-1:0] n, logic rev);
    logic [WL-1:0]  m;
    logic [QWL-1:0] r;
    m = n[WL-1] ? WL'(-n) : WL'(n);
    r = ((QWL'(m) << KL) + HALF) >> KR;
    return sat24(n[WL-1] ^ rev, r[24:0], |(r >> 25));
  endfunction

  // ---------------- stage 1: decode and products ----------------
  logic signed [WL-1:0]  a_l, b_l, c_l;
  logic signed [WL-1:0]  n_c [4];
  err_e                  err_c;
  logic                  dsel_c;
  logic signed [DW-1:0]  d_c;
  logic signed [31:0]    ac_c, bc_c;
  logic signed [ADW-1:0] ad_c, bd_c;

  assign a_l  = WL'(in_data.coord_u);
  assign b_l  = WL'(in_data.coord_v);
  assign c_l  = WL'(in_data.coord_w);
  assign d_c  = DW'(S_L) - DW'(in_data.coord_w);
  assign ac_c = in_data.coord_u * in_data.coord_w;
  assign bc_c = in_data.coord_v * in_data.coord_w;
  assign ad_c = ADW'(in_data.coord_u) * ADW'(d_c);
  assign bd_c = ADW'(in_data.coord_v) * ADW'(d_c);

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      n_c[k] = '0;
    end
    err_c  = ERR_OK;
    dsel_c = 1'b0;
    case (elem_e'(in_data.element_type))
      EL_LINE: begin
        if (in_data.facet_number == 3'd1) n_c[0] = S_L <<< 2;
        else err_c = ERR_FACET;
      end
      EL_TRI: begin
        if (in_data.facet_number == 3'd1) n_c[2] = S_L <<< 3;
        else err_c = ERR_FACET;
      end
      EL_QUAD: begin
        if (in_data.facet_number == 3'd1) n_c[2] = S_L <<< 1;
        else err_c = ERR_FACET;
      end
      EL_TET: begin
        n_c[0] = a_l <<< 3;
        n_c[1] = b_l <<< 3;
        n_c[2] = c_l <<< 3;
        n_c[3] = (S_L <<< 4) + (S_L <<< 3);
        case (in_data.facet_number)
          3'd1: n_c[1] = -((S_L - b_l) <<< 3);
          3'd2: n_c[2] = -((S_L - c_l) <<< 3);
          3'd3: n_c[0] = -((S_L - a_l) <<< 3);
          3'd4: ;
          default: err_c = ERR_FACET;
        endcase
      end
      EL_HEX: begin
        n_c[3] = S_L;
        case (in_data.facet_number)
          3'd1: n_c[1] = b_l - S_L;
          3'd2: n_c[2] = c_l - S_L;
          3'd3: n_c[0] = a_l - S_L;
          3'd4: n_c[0] = S_L + a_l;
          3'd5: n_c[1] = S_L + b_l;
          3'd6: n_c[2] = S_L + c_l;
          default: err_c = ERR_FACET;
        endcase
      end
      EL_PRISM: begin
        case (in_data.facet_number)
          3'd1: begin
            n_c[0] = a_l <<< 2;
            n_c[1] = (b_l - S_L) <<< 2;
            n_c[3] = S_L <<< 3;
          end
          3'd2: begin
            n_c[2] = (c_l - S_L) <<< 2;
            n_c[3] = S_L <<< 2;
          end
          3'd3: begin
            n_c[0] = (a_l - S_L) <<< 2;
            n_c[1] = b_l <<< 2;
            n_c[3] = S_L <<< 3;
          end
          3'd4: begin
            n_c[0] = a_l <<< 2;
            n_c[1] = b_l <<< 2;
            n_c[3] = S_L <<< 3;
          end
          3'd5: begin
            n_c[2] = (S_L + c_l) <<< 2;
            n_c[3] = S_L <<< 2;
          end
          default: err_c = ERR_FACET;
        endcase
      end
      EL_PYRAMID: begin
        if (in_data.facet_number == 3'd0 || in_data.facet_number > 3'd5) begin
          err_c = ERR_FACET;
        end else if (c_l == S_L) begin
          // apex: fixed vectors, zero divergence
          case (in_data.facet_number)
            3'd1: begin n_c[1] = -(S_L <<< 1); n_c[2] = S_L; end
            3'd3: begin n_c[0] = -(S_L <<< 1); n_c[2] = S_L; end
            3'd4: begin n_c[0] = S_L <<< 1;    n_c[2] = S_L; end
            3'd5: begin n_c[1] = S_L <<< 1;    n_c[2] = S_L; end
            default: ;
          endcase
        end else begin
          n_c[3] = (S_L <<< 1) + S_L;
          if (in_data.facet_number == 3'd2) begin
            n_c[0] = a_l;
            n_c[1] = b_l;
            n_c[2] = c_l - S_L;
          end else begin
            n_c[2] = c_l;
            dsel_c = 1'b1;
          end
        end
      end
      default: err_c = ERR_ELEM;
    endcase
    if (err_c != ERR_OK) begin
      for (int k = 0; k < 4; k++) begin
        n_c[k] = '0;
      end
    end
  end

  logic signed [WL-1:0]  n_r [4];
  err_e                  err_r;
  logic                  dsel_r, rev_r;
  logic [2:0]            fn_r;
  logic signed [DW-1:0]  d_r;
  logic signed [15:0]    a_r, b_r;
  logic signed [31:0]    ac_r, bc_r;
  logic signed [ADW-1:0] ad_r, bd_r;

  always_ff @(posedge clk) begin
    if (en) begin
      n_r    <= n_c;
      err_r  <= err_c;
      dsel_r <= dsel_c;
      rev_r  <= in_data.facet_reversed;
      fn_r   <= in_data.facet_number;
      d_r    <= d_c;
      a_r    <= in_data.coord_u;
      b_r    <= in_data.coord_v;
      ac_r   <= ac_c;
      bc_r   <= bc_c;
      ad_r   <= ad_c;
      bd_r   <= bd_c;
    end
  end

  // ---------------- stage 2: numerators and rounding ----------------
  logic signed [PW-1:0] two_sd, as_c, bs_c, p_c, q_c, pf_c, qf_c;
  logic [PW-1:0]        pm_c, qm_c;
  side_t                side_c;
  res_t                 lr [4];

  assign two_sd = PW'(d_r) <<< (IN_FRAC_BITS + 1);
  assign as_c   = PW'(a_r) <<< IN_FRAC_BITS;
  assign bs_c   = PW'(b_r) <<< IN_FRAC_BITS;

  always_comb begin
    case (fn_r)
      3'd1: begin
        p_c = -PW'(ac_r);
        q_c = -two_sd + PW'(bd_r) + bs_c;
      end
      3'd3: begin
        p_c = -two_sd + PW'(ad_r) + as_c;
        q_c = -PW'(bc_r);
      end
      3'd4: begin
        p_c = two_sd + PW'(ad_r) + as_c;
        q_c = -PW'(bc_r);
      end
      default: begin
        p_c = -PW'(ac_r);
        q_c = two_sd + PW'(bd_r) + bs_c;
      end
    endcase
    // w above one: fold the sign of (1 - w) into the numerator
    pf_c = d_r[DW-1] ? -p_c : p_c;
    qf_c = d_r[DW-1] ? -q_c : q_c;
    pm_c = pf_c[PW-1] ? PW'(-pf_c) : PW'(pf_c);
    qm_c = qf_c[PW-1] ? PW'(-qf_c) : PW'(qf_c);
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      lr[k] = lin_round(n_r[k], rev_r);
    end
    side_c.err     = err_r;
    side_c.div_sel = dsel_r;
    for (int k = 0; k < 4; k++) begin
      side_c.sat[k] = lr[k].sat;
      side_c.val[k] = lr[k].val;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_o <= side_c;
      pnum_o <= (NW'(pm_c) << EL) >> ER;
      qnum_o <= (NW'(qm_c) << EL) >> ER;
      den_o  <= d_r[DW-1] ? DW'(-d_r) : DW'(d_r);
      pneg_o <= pf_c[PW-1] ^ rev_r;
      qneg_o <= qf_c[PW-1] ^ rev_r;
    end
  end

endmodule

// File: design/fbf_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbf_div
// Pipelined restoring divider: up to DIV_STEPS quotient bits per stage, with an early
// overflow flag when the quotient does not fit in QUOT_BITS.
// ----------------------------------------------------------------------------
module fbf_div #(
  parameter int NW = 52,
  parameter int DW = 18
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic [NW-1:0]                 num_i,
  input  logic [DW-1:0]                 den_i,
  input  logic                          neg_i,
  output logic [fbf_pkg::QUOT_BITS-1:0] quo_o,
  output logic                          ovf_o,
  output logic                          neg_o
);
  import fbf_pkg::*;

  localparam int QB   = QUOT_BITS;
  localparam int NS   = DIV_STAGES;
  localparam int HW   = NW - QB;
  localparam int CMPW = (HW > DW) ? HW : DW;

  logic [DW-1:0] rem_r [NS];
  logic [DW-1:0] den_r [NS];
  logic [QB-1:0] quo_r [NS];
  logic [QB-1:0] lo_r  [NS];
  logic          ovf_r [NS];
  logic          neg_r [NS];

  for (genvar s = 0; s < NS; s++) begin : g_stage
    logic [DW-1:0] rem_in, rem_v, den_in;
    logic [QB-1:0] quo_in, quo_v, lo_in;
    logic          ovf_in, neg_in;
    logic [DW:0]   t;

    if (s == 0) begin : g_first
      // the high part must be below the divisor, or the quotient overflows
      assign rem_in = DW'(num_i >> QB);
      assign quo_in = '0;
      assign lo_in  = QB'(num_i);
      assign den_in = den_i;
      assign ovf_in = (CMPW'(num_i >> QB) >= CMPW'(den_i));
      assign neg_in = neg_i;
    end else begin : g_next
      assign rem_in = rem_r[s-1];
      assign quo_in = quo_r[s-1];
      assign lo_in  = lo_r[s-1];
      assign den_in = den_r[s-1];
      assign ovf_in = ovf_r[s-1];
      assign neg_in = neg_r[s-1];
    end

    // one quotient bit per step
    always_comb begin
      rem_v = rem_in;
      quo_v = quo_in;
      t     = '0;
      for (int j = 0; j < DIV_STEPS; j++) begin
        if (s * DIV_STEPS + j < QB) begin
          t = {rem_v, lo_in[QB - 1 - (s * DIV_STEPS + j)]};
          if (t >= {1'b0, den_in}) begin
            rem_v = DW'(t - {1'b0, den_in});
            quo_v[QB - 1 - (s * DIV_STEPS + j)] = 1'b1;
          end else begin
            rem_v = t[DW-1:0];
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s] <= rem_v;
        quo_r[s] <= quo_v;
        lo_r[s]  <= lo_in;
        den_r[s] <= den_in;
        ovf_r[s] <= ovf_in;
        neg_r[s] <= neg_in;
      end
    end
  end

  assign quo_o = quo_r[NS-1];
  assign ovf_o = ovf_r[NS-1];
  assign neg_o = neg_r[NS-1];

endmodule

// File: design/facet_basis_function_eval_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// facet_basis_function_eval_unit
// Lowest-order facet basis vector and divergence on reference elements.
//
//   channel | dir | handshake            | word
//   in_     | in  | in_valid / in_ready  | fbf_pkg::in_word_t
//   out_    | out | out_valid / out_ready| fbf_pkg::out_word_t
//
// One word per cycle sustained while the output is not stalled. The registers
// in order are two numerator stages, the divider stages for the pyramid
// x/y components, and the output register.
// The pipeline advances as one whole when the output register is empty or
// taken; a stall freezes every stage. in_ready = !out_valid | out_ready.
// Synchronous active-low reset clears the valid bits only.
// ----------------------------------------------------------------------------
module facet_basis_function_eval_unit #(
  parameter int IN_FRAC_BITS  = 14,
  parameter int OUT_FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  fbf_pkg::in_word_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output fbf_pkg::out_word_t  out_data
);
  import fbf_pkg::*;

  localparam int NW  = nw_of(IN_FRAC_BITS, OUT_FRAC_BITS);
  localparam int DW  = dw_of(IN_FRAC_BITS);
  localparam int LAT = 2 + DIV_STAGES;

  logic                 en;
  logic [LAT-1:0]       vld_r;
  logic                 out_valid_r;
  out_word_t            out_r, out_nxt;
  side_t                side_s2;
  side_t [DIV_STAGES-1:0] side_r;
  logic [NW-1:0]        pnum, qnum;
  logic [DW-1:0]        den;
  logic                 pneg, qneg;
  logic [QUOT_BITS-1:0] pquo, qquo;
  logic                 povf, qovf, pneg_d, qneg_d;

  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  fbf_numer #(
    .IN_FRAC_BITS  (IN_FRAC_BITS),
    .OUT_FRAC_BITS (OUT_FRAC_BITS)
  ) u_numer (
    .clk     (clk),
    .en      (en),
    .in_data (in_data),
    .side_o  (side_s2),
    .pnum_o  (pnum),
    .qnum_o  (qnum),
    .den_o   (den),
    .pneg_o  (pneg),
    .qneg_o  (qneg)
  );

  fbf_div #(.NW(NW), .DW(DW)) u_div_x (
    .clk   (clk),
    .en    (en),
    .num_i (pnum),
    .den_i (den),
    .neg_i (pneg),
    .quo_o (pquo),
    .ovf_o (povf),
    .neg_o (pneg_d)
  );

  fbf_div #(.NW(NW), .DW(DW)) u_div_y (
    .clk   (clk),
    .en    (en),
    .num_i (qnum),
    .den_i (den),
    .neg_i (qneg),
    .quo_o (qquo),
    .ovf_o (qovf),
    .neg_o (qneg_d)
  );

  // side data follows the divider
  always_ff @(posedge clk) begin
    if (en) begin
      side_r <= {side_r[DIV_STAGES-2:0], side_s2};
    end
  end

  // final rounding of the quotients and merge
  logic [QUOT_BITS:0] pinc, qinc;
  res_t               pres, qres;
  side_t              sd;
  logic               sat_any;

  always_comb begin
    sd      = side_r[DIV_STAGES-1];
    pinc    = {1'b0, pquo} + 1'b1;
    qinc    = {1'b0, qquo} + 1'b1;
    pres    = sat24(pneg_d, pinc[QUOT_BITS:1], povf);
    qres    = sat24(qneg_d, qinc[QUOT_BITS:1], qovf);
    sat_any = |sd.sat;
    out_nxt.vec_x      = sd.val[0];
    out_nxt.vec_y      = sd.val[1];
    out_nxt.vec_z      = sd.val[2];
    out_nxt.divergence = sd.val[3];
    if (sd.div_sel) begin
      out_nxt.vec_x = pres.val;
      out_nxt.vec_y = qres.val;
      sat_any       = sat_any | pres.sat | qres.sat;
    end
    if (sd.err != ERR_OK) out_nxt.error_code = sd.err;
    else if (sat_any)     out_nxt.error_code = ERR_SAT;
    else                  out_nxt.error_code = ERR_OK;
  end

  // valid bits and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r       <= {vld_r[LAT-2:0], in_valid};
      out_valid_r <= vld_r[LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// File: design/fbf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbf_checker
// Port-level checks for the facet basis function evaluator, bound to the top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fbf_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input fbf_pkg::in_word_t   in_data,
  input logic                out_valid,
  input logic                out_ready,
  input fbf_pkg::out_word_t  out_data
);
  import fbf_pkg::*;

  // an offered input word waits unchanged until taken
  `CHK_NXT(a_in_hold, in_valid && !in_ready, in_valid && $stable(in_data))

  // a stalled result word stays put
  `CHK_NXT(a_out_hold, out_valid && !out_ready, out_valid)
  `CHK_NXT(a_out_stable, out_valid && !out_ready, $stable(out_data))

  // input side is open whenever the output register is free
  `CHK_IMP(a_ready_free, !out_valid || out_ready, in_ready)

  // facet and element errors come with all-zero values
  `CHK_IMP(a_err_zero,
    out_valid && (out_data.error_code == ERR_FACET || out_data.error_code == ERR_ELEM),
    out_data.vec_x == 24'sd0 && out_data.vec_y == 24'sd0 &&
    out_data.vec_z == 24'sd0 && out_data.divergence == 24'sd0)

endmodule

bind facet_basis_function_eval_unit fbf_checker u_fbf_checker (.*);

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the facet basis function evaluator. A directed
// table covers every element, every facet, the pyramid apex, bad facets and
// unknown elements, and coordinate extremes. Random words follow, checked
// against an exact-rational predictor. Both channels idle at random, and
// the receiver holds off once for a long stretch to fill the pipeline.
// ----------------------------------------------------------------------------
module tb_top;
  import fbf_pkg::*;

  localparam int     N_RANDOM  = 1250;
  localparam int     MAX_CYC   = 600000;
  localparam longint ONE_IN    = 64'sd16384;   // 1.0 in Q2.14
  localparam longint Q_LIMIT   = 64'sd1 << 26;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_word_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_word_t out_data;

  out_word_t basis_expected[$];
  int        n_errors;
  int        n_cycles;
  bit        long_hold_done;

  facet_basis_function_eval_unit u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // round num/den to Q8.16, ties away from zero, saturating
  function automatic logic [23:0] to_q816(input longint num, input longint den,
                                          inout bit sat);
    longint m, q, r;
    bit     big;
    m   = (num < 0) ? -num : num;
    q   = m / den;
    r   = m % den;
    big = (q > Q_LIMIT);
    for (int i = 0; i < 17 && !big; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= den) begin
        r = r - den;
        q = q | 1;
      end
      if (q > Q_LIMIT) big = 1'b1;
    end
    if (!big) q = (q + 1) >>> 1;
    if (num < 0) begin
      if (big || q > 8388608) begin
        sat = 1'b1;
        return OUT_MIN;
      end
      return 24'(-q);
    end
    if (big || q > 8388607) begin
      sat = 1'b1;
      return OUT_MAX;
    end
    return 24'(q);
  endfunction

  // exact basis vector and divergence for one word
  function automatic out_word_t eval_basis(input in_word_t w);
    out_word_t res;
    longint    n[4];
    longint    dn[4];
    longint    a, b, c, s, d, p, q;
    logic [1:0] err;
    bit        sat;
    logic [23:0] v[4];
    a = w.coord_u;
    b = w.coord_v;
    c = w.coord_w;
    s = ONE_IN;
    err = ERR_OK;
    sat = 1'b0;
    for (int k = 0; k < 4; k++) begin
      n[k]  = 0;
      dn[k] = 4 * s;
    end
    case (elem_e'(w.element_type))
      EL_LINE: begin
        if (w.facet_number == 1) n[0] = 4 * s; else err = ERR_FACET;
      end
      EL_TRI: begin
        if (w.facet_number == 1) n[2] = 8 * s; else err = ERR_FACET;
      end
      EL_QUAD: begin
        if (w.facet_number == 1) n[2] = 2 * s; else err = ERR_FACET;
      end
      EL_TET: begin
        n[0] = 8 * a; n[1] = 8 * b; n[2] = 8 * c; n[3] = 24 * s;
        case (w.facet_number)
          1: n[1] = -8 * (s - b);
          2: n[2] = -8 * (s - c);
          3: n[0] = -8 * (s - a);
          4: ;
          default: err = ERR_FACET;
        endcase
      end
      EL_HEX: begin
        n[3] = s;
        case (w.facet_number)
          1: n[1] = -(s - b);
          2: n[2] = -(s - c);
          3: n[0] = -(s - a);
          4: n[0] = s + a;
          5: n[1] = s + b;
          6: n[2] = s + c;
          default: err = ERR_FACET;
        endcase
      end
      EL_PRISM: begin
        case (w.facet_number)
          1: begin n[0] = 4 * a; n[1] = -4 * (s - b); n[3] = 8 * s; end
          2: begin n[2] = -4 * (s - c); n[3] = 4 * s; end
          3: begin n[0] = -4 * (s - a); n[1] = 4 * b; n[3] = 8 * s; end
          4: begin n[0] = 4 * a; n[1] = 4 * b; n[3] = 8 * s; end
          5: begin n[2] = 4 * (s + c); n[3] = 4 * s; end
          default: err = ERR_FACET;
        endcase
      end
      EL_PYRAMID: begin
        if (w.facet_number < 1 || w.facet_number > 5) begin
          err = ERR_FACET;
        end else if (c == s) begin
          // apex: fixed vectors, zero divergence
          case (w.facet_number)
            1: begin n[1] = -2 * s; n[2] = s; end
            3: begin n[0] = -2 * s; n[2] = s; end
            4: begin n[0] = 2 * s;  n[2] = s; end
            5: begin n[1] = 2 * s;  n[2] = s; end
            default: ;
          endcase
        end else begin
          d = s - c;
          n[3] = 3 * s;
          if (w.facet_number == 2) begin
            n[0] = a; n[1] = b; n[2] = -(s - c);
          end else begin
            n[2] = c;
            p = 0;
            q = 0;
            case (w.facet_number)
              1: begin p = -a * c; q = -2 * s * d + b * d + b * s; end
              3: begin p = -2 * s * d + a * d + a * s; q = -b * c; end
              4: begin p = 2 * s * d + a * d + a * s;  q = -b * c; end
              default: begin p = -a * c; q = 2 * s * d + b * d + b * s; end
            endcase
            // keep the denominator positive
            if (d < 0) begin
              p = -p;
              q = -q;
            end
            n[0]  = p;
            n[1]  = q;
            dn[0] = 4 * s * ((d < 0) ? -d : d);
            dn[1] = dn[0];
          end
        end
      end
      default: err = ERR_ELEM;
    endcase
    if (err != ERR_OK) begin
      for (int k = 0; k < 4; k++) begin
        n[k]  = 0;
        dn[k] = 4 * s;
      end
    end
    for (int k = 0; k < 4; k++) begin
      v[k] = to_q816(w.facet_reversed ? -n[k] : n[k], dn[k], sat);
    end
    if (err == ERR_OK && sat) err = ERR_SAT;
    res.vec_x      = v[0];
    res.vec_y      = v[1];
    res.vec_z      = v[2];
    res.divergence = v[3];
    res.error_code = err;
    return res;
  endfunction

  function automatic in_word_t mk_word(input elem_e et, input int fn, input int u,
                                       input int v, input int w, input bit rev);
    in_word_t r;
    r.element_type   = et;
    r.facet_number   = 3'(fn);
    r.coord_u        = 16'(u);
    r.coord_v        = 16'(v);
    r.coord_w        = 16'(w);
    r.facet_reversed = rev;
    return r;
  endfunction

  function automatic out_word_t mk_res(input int x, input int y, input int z,
                                       input int dv, input err_e e);
    out_word_t r;
    r.vec_x      = 24'(x);
    r.vec_y      = 24'(y);
    r.vec_z      = 24'(z);
    r.divergence = 24'(dv);
    r.error_code = e;
    return r;
  endfunction

  // idle length: mostly none or short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic int pick_coord(input bit pyr_w);
    int r;
    r = $urandom_range(0, 99);
    if (pyr_w && r < 20) return 16384;
    if (pyr_w && r < 32) return 16384 + $urandom_range(0, 16) - 8;
    if (r < 45) return $urandom_range(0, 65535) - 32768;
    if (r < 80) return $urandom_range(0, 16384);
    case ($urandom_range(0, 3))
      0: return -32768;
      1: return 32767;
      2: return 0;
      default: return -16384;
    endcase
  endfunction

  function automatic in_word_t rand_word();
    int    r, fn;
    elem_e et;
    int    nf[7] = '{1, 1, 1, 4, 6, 5, 5};
    r = $urandom_range(0, 99);
    if (r < 40) et = EL_PYRAMID;
    else et = elem_e'($urandom_range(0, 6));
    if ($urandom_range(0, 99) < 12) begin
      et = elem_e'($urandom_range(0, 7));
      fn = $urandom_range(0, 7);
    end else begin
      fn = $urandom_range(1, nf[et]);
    end
    return mk_word(et, fn, pick_coord(1'b0), pick_coord(1'b0),
                   pick_coord(et == EL_PYRAMID), $urandom_range(0, 1));
  endfunction

  // offer one word; may idle first, keeps valid high when there is no gap
  task automatic send_word(input in_word_t w, input bit typed, input out_word_t e);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    basis_expected.push_back(typed ? e : eval_basis(w));
  endtask

  // stimulus
  initial begin
    in_word_t  dir_word[$];
    bit        dir_typed[$];
    out_word_t dir_res[$];
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    n_errors = 0;

    // rows with the result read off by hand
    dir_word.push_back(mk_word(EL_LINE, 1, 12345, 0, 0, 0));
    dir_res.push_back(mk_res(65536, 0, 0, 0, ERR_OK));
    dir_word.push_back(mk_word(EL_LINE, 1, 0, 0, 0, 1));
    dir_res.push_back(mk_res(-65536, 0, 0, 0, ERR_OK));
    dir_word.push_back(mk_word(EL_LINE, 0, 0, 0, 0, 0));
    dir_res.push_back(mk_res(0, 0, 0, 0, ERR_FACET));
    dir_word.push_back(mk_word(EL_TRI, 1, -32768, 32767, 0, 0));
    dir_res.push_back(mk_res(0, 0, 131072, 0, ERR_OK));
    dir_word.push_back(mk_word(EL_TRI, 2, 0, 0, 0, 0));
    dir_res.push_back(mk_res(0, 0, 0, 0, ERR_FACET));
    dir_word.push_back(mk_word(EL_QUAD, 1, 0, 0, 0, 0));
    dir_res.push_back(mk_res(0, 0, 32768, 0, ERR_OK));
    dir_word.push_back(mk_word(EL_UNKNOWN, 1, 0, 0, 0, 1));
    dir_res.push_back(mk_res(0, 0, 0, 0, ERR_ELEM));
    dir_word.push_back(mk_word(EL_PYRAMID, 1, 500, -700, 16384, 0));
    dir_res.push_back(mk_res(0, -32768, 16384, 0, ERR_OK));
    dir_word.push_back(mk_word(EL_PYRAMID, 2, 500, 700, 16384, 0));
    dir_res.push_back(mk_res(0, 0, 0, 0, ERR_OK));
    dir_word.push_back(mk_word(EL_PYRAMID, 3, 0, 0, 16384, 0));
    dir_res.push_back(mk_res(-32768, 0, 16384, 0, ERR_OK));
    dir_word.push_back(mk_word(EL_PYRAMID, 4, 0, 0, 16384, 1));
    dir_res.push_back(mk_res(-32768, 0, -16384, 0, ERR_OK));
    dir_word.push_back(mk_word(EL_PYRAMID, 5, 0, 0, 16384, 0));
    dir_res.push_back(mk_res(0, 32768, 16384, 0, ERR_OK));
    dir_word.push_back(mk_word(EL_PYRAMID, 6, 0, 0, 0, 0));
    dir_res.push_back(mk_res(0, 0, 0, 0, ERR_FACET));
    dir_word.push_back(mk_word(EL_PYRAMID, 0, 0, 0, 0, 0));
    dir_res.push_back(mk_res(0, 0, 0, 0, ERR_FACET));
    foreach (dir_res[i]) dir_typed.push_back(1'b1);

    // rows checked by the predictor
    for (int f = 1; f <= 5; f++) dir_word.push_back(mk_word(EL_TET, f, -32768, 32767,
                                                            -32768, f[0]));
    for (int f = 1; f <= 7; f++) dir_word.push_back(mk_word(EL_HEX, f, 32767, -32768,
                                                            32767, f[0]));
    for (int f = 1; f <= 6; f++) dir_word.push_back(mk_word(EL_PRISM, f, -32768, -32768,
                                                            32767, f[0]));
    // pyramid near the apex saturates; beyond the apex 1 - w goes negative
    dir_word.push_back(mk_word(EL_PYRAMID, 1, 32767, 32767, 16383, 0));
    dir_word.push_back(mk_word(EL_PYRAMID, 3, -32768, 100, 16385, 1));
    dir_word.push_back(mk_word(EL_PYRAMID, 4, 8192, -8192, 32767, 0));
    dir_word.push_back(mk_word(EL_PYRAMID, 5, 4000, 3000, -32768, 1));
    while (dir_typed.size() < dir_word.size()) begin
      dir_typed.push_back(1'b0);
      dir_res.push_back('0);
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_word[i]) send_word(dir_word[i], dir_typed[i], dir_res[i]);
    for (int i = 0; i < N_RANDOM; i++) send_word(rand_word(), 1'b0, '0);
    in_valid <= 1'b0;

    while (basis_expected.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (n_errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // result side backpressure, with one long hold-off after some traffic
  initial begin
    int gap;
    out_ready      = 1'b0;
    long_hold_done = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!long_hold_done && n_cycles > 2000) begin
        long_hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (300) @(posedge clk);
      end else if ($urandom_range(0, 9) == 0) begin
        // a stretch with no idling
        out_ready <= 1'b1;
        repeat ($urandom_range(30, 80)) @(posedge clk);
      end else begin
        gap = pick_gap();
        if (gap > 0) begin
          out_ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  // compare each taken word with the oldest expectation
  always @(posedge clk) begin
    out_word_t e;
    if (rst_n && out_valid && out_ready) begin
      if (basis_expected.size() == 0) begin
        $display("%0t: unexpected word %h", $time, out_data);
        n_errors++;
      end else begin
        e = basis_expected.pop_front();
        if (out_data.vec_x !== e.vec_x) begin
          $display("%0t: vec_x exp %0d got %0d", $time, e.vec_x, out_data.vec_x);
          n_errors++;
        end
        if (out_data.vec_y !== e.vec_y) begin
          $display("%0t: vec_y exp %0d got %0d", $time, e.vec_y, out_data.vec_y);
          n_errors++;
        end
        if (out_data.vec_z !== e.vec_z) begin
          $display("%0t: vec_z exp %0d got %0d", $time, e.vec_z, out_data.vec_z);
          n_errors++;
        end
        if (out_data.divergence !== e.divergence) begin
          $display("%0t: divergence exp %0d got %0d", $time, e.divergence,
                   out_data.divergence);
          n_errors++;
        end
        if (out_data.error_code !== e.error_code) begin
          $display("%0t: error_code exp %0d got %0d", $time, e.error_code,
                   out_data.error_code);
          n_errors++;
        end
      end
    end
  end

  // watchdog
  initial begin
    n_cycles = 0;
    forever begin
      @(posedge clk);
      n_cycles++;
      if (n_cycles > MAX_CYC) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

endmodule
